// ===== rtl/core/rmvs_pkg.sv =====
// Shared constants for the running mean and variance statistics block.
package rmvs_pkg;

  // Default parameter values
  localparam int unsigned SampleWidthDef = 32;
  localparam int unsigned FracBitsDef    = 16;
  localparam int unsigned CountWidthDef  = 32;

  // Mean accumulator and divider dividend width (mean held in units 2^-32)
  localparam int unsigned AccWidth  = 64;
  // Squared-difference sum width and its saturation limit
  localparam int unsigned SumWidth  = 63;
  localparam logic [SumWidth-1:0] SumLimit = {SumWidth{1'b1}};
  // Width of the 32-bit result fields
  localparam int unsigned OutWidth  = 32;
  // Half of the product operands
  localparam int unsigned HalfWidth = 32;
  // Width of floor(a*b / 2^32) for two AccWidth operands
  localparam int unsigned ProdWidth = 2 * AccWidth - HalfWidth;

endpackage

// ===== rtl/core/rmvs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module rmvs_div #(
  parameter int unsigned DIVISOR_WIDTH = rmvs_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rmvs_pkg::AccWidth-1:0] dividend_i,
  input  logic [DIVISOR_WIDTH-1:0]      divisor_i,
  output logic                          done_o,
  output logic [rmvs_pkg::AccWidth-1:0] quotient_o
);

  localparam int unsigned Steps  = rmvs_pkg::AccWidth;
  localparam int unsigned CntW   = $clog2(Steps + 1);

  logic [CntW-1:0]               cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [rmvs_pkg::AccWidth-1:0] quo_q;
  logic [DIVISOR_WIDTH-1:0]      rem_q;
  logic [DIVISOR_WIDTH-1:0]      div_q;

  // trial remainder: old remainder shifted with the next dividend bit
  logic [DIVISOR_WIDTH:0] trial;
  logic [DIVISOR_WIDTH:0] diff;

  assign trial = {rem_q, quo_q[rmvs_pkg::AccWidth-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        if (trial >= {1'b0, div_q}) begin
          rem_q <= diff[DIVISOR_WIDTH-1:0];
          quo_q <= {quo_q[rmvs_pkg::AccWidth-2:0], 1'b1};
        end else begin
          rem_q <= trial[DIVISOR_WIDTH-1:0];
          quo_q <= {quo_q[rmvs_pkg::AccWidth-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/rmvs_sqprod.sv =====
// Saturating scaled product floor(a*b/2^32) from four 32x32 partial products.
module rmvs_sqprod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rmvs_pkg::AccWidth-1:0] a_i,
  input  logic [rmvs_pkg::AccWidth-1:0] b_i,
  output logic                          done_o,
  output logic [rmvs_pkg::SumWidth-1:0] prod_o
);

  localparam int unsigned HW = rmvs_pkg::HalfWidth;
  localparam int unsigned AW = rmvs_pkg::AccWidth;
  localparam int unsigned PW = rmvs_pkg::ProdWidth;

  // partial order: a0*b0, a1*b0, a0*b1, a1*b1 (bit 0 picks a half, bit 1 b half)
  localparam logic [2:0] LastMul = 3'd3;
  localparam logic [2:0] LastAdd = 3'd4;
  localparam logic [2:0] SatStep = 3'd5;

  logic [AW-1:0]              a_q, b_q;
  logic [2:0]                 cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [2*HW-1:0]            mul_q;
  logic [PW-1:0]              acc_q;
  logic [rmvs_pkg::SumWidth-1:0] prod_q;

  logic [HW-1:0] a_half, b_half;
  logic [1:0]    tag;
  logic [PW-1:0] term;

  assign a_half = cnt_q[0] ? a_q[AW-1:HW] : a_q[HW-1:0];
  assign b_half = cnt_q[1] ? b_q[AW-1:HW] : b_q[HW-1:0];
  assign tag    = 2'(cnt_q - 3'd1);

  always_comb begin
    case (tag)
      2'd0:    term = PW'(mul_q[2*HW-1:HW]);
      2'd3:    term = {mul_q, {HW{1'b0}}};
      default: term = PW'(mul_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q <= LastMul) begin
          mul_q <= (2*HW)'(a_half) * (2*HW)'(b_half);
        end
        if (cnt_q != 3'd0 && cnt_q <= LastAdd) begin
          acc_q <= acc_q + term;
        end
        if (cnt_q == SatStep) begin
          prod_q <= (acc_q >= PW'(rmvs_pkg::SumLimit)) ? rmvs_pkg::SumLimit
                                                       : acc_q[rmvs_pkg::SumWidth-1:0];
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/core/running_mean_variance_stats.sv =====
// Top level: Welford running mean / variance with a shared iterative divider.
//
//  channel   dir  handshake                        payload
//  sample    in   sample_valid_i / sample_stall_o  sample_i (signed, Q.FRAC_BITS)
//  result    out  result_valid_o / result_stall_i  sample_count_o, largest_magnitude_o,
//                                                  running_mean_o, sample_variance_o
//
// Each word takes two passes through the shared divider (start, 64 steps, done; mean
//   step then variance; the first word skips the variance pass), one pass through the
//   partial-product unit (start, 6 steps, done) and single sequencer steps.
// One word in flight; sample_stall_o is high from accept until the sequencer is
//   back in idle. A finished result sits in the output register, so the next word
//   is taken while result_stall_i holds the previous one.
// The sequencer waits in its last step while the output register is still full and stalled.
// Reset (rst_ni low, async) clears count, peak, mean, sum and all control state.
module running_mean_variance_stats #(
  parameter int unsigned SAMPLE_WIDTH = rmvs_pkg::SampleWidthDef,
  parameter int unsigned FRAC_BITS    = rmvs_pkg::FracBitsDef,
  parameter int unsigned COUNT_WIDTH  = rmvs_pkg::CountWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample channel
  input  logic                                 sample_valid_i,
  output logic                                 sample_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  // result channel
  output logic                                 result_valid_o,
  input  logic                                 result_stall_i,
  output logic [rmvs_pkg::OutWidth-1:0]        sample_count_o,
  output logic [rmvs_pkg::OutWidth-1:0]        largest_magnitude_o,
  output logic signed [rmvs_pkg::OutWidth-1:0] running_mean_o,
  output logic [rmvs_pkg::SumWidth-1:0]        sample_variance_o
);

  localparam int unsigned AW         = rmvs_pkg::AccWidth;
  localparam int unsigned SW         = rmvs_pkg::SumWidth;
  localparam int unsigned OW         = rmvs_pkg::OutWidth;
  // mean kept with 32 fraction bits; sample has FRAC_BITS
  localparam int unsigned MEAN_SHIFT = rmvs_pkg::HalfWidth - FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,    // wait for a sample word
    ST_DELTA,   // peak, count, delta = scaled - mean
    ST_MAG,     // |delta|, kick mean division
    ST_MDIV,    // wait |delta| / n, update mean
    ST_DELTA2,  // delta2 = scaled - new mean
    ST_PSTART,  // kick |delta| * |delta2| / 2^32
    ST_PROD,    // wait product, saturating sum update
    ST_VSTART,  // kick sum / (n-1) or zero variance
    ST_VDIV,    // wait variance quotient
    ST_OUT      // load output register
  } state_e;

  state_e state_q;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [COUNT_WIDTH-1:0]         count_q;
  logic [SAMPLE_WIDTH-1:0]        peak_q;
  logic signed [AW-1:0]           mean_q;
  logic [SW-1:0]                  sum_q;
  logic [AW-1:0]                  scaled_q;
  logic [AW-1:0]                  delta_q;
  logic [AW-1:0]                  dmag_q;
  logic                           neg_q;
  logic [SW-1:0]                  var_q;

  logic                   div_start_q;
  logic [AW-1:0]          div_dividend_q;
  logic [COUNT_WIDTH-1:0] div_divisor_q;
  logic                   div_done;
  logic [AW-1:0]          div_quot;

  logic          prod_start_q;
  logic          prod_done;
  logic [SW-1:0] prod;

  logic                    res_valid_q;
  logic [OW-1:0]           res_count_q;
  logic [OW-1:0]           res_peak_q;
  logic signed [OW-1:0]    res_mean_q;
  logic [SW-1:0]           res_var_q;

  // sample datapath
  logic signed [AW-1:0]    s_ext;
  logic [AW-1:0]           scaled;
  logic [AW-1:0]           s_abs;
  logic [SAMPLE_WIDTH-1:0] s_mag;
  logic [AW-1:0]           delta_abs;
  logic [AW-1:0]           sum_wide;
  logic [SW-1:0]           sum_next;

  assign s_ext     = AW'(sample_q);
  assign scaled    = AW'(s_ext <<< MEAN_SHIFT);
  assign s_abs     = s_ext[AW-1] ? (~s_ext) + AW'(1) : s_ext;
  assign s_mag     = SAMPLE_WIDTH'(s_abs);
  assign delta_abs = delta_q[AW-1] ? (~delta_q) + AW'(1) : delta_q;
  // sum and product both stay at or below the limit, so this cannot wrap
  assign sum_wide  = {1'b0, sum_q} + {1'b0, prod};
  assign sum_next  = (sum_wide >= {1'b0, rmvs_pkg::SumLimit}) ? rmvs_pkg::SumLimit
                                                              : sum_wide[SW-1:0];

  rmvs_div #(
    .DIVISOR_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend_q),
    .divisor_i  (div_divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  rmvs_sqprod u_sqprod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_start_q),
    .a_i     (dmag_q),
    .b_i     (delta_abs),
    .done_o  (prod_done),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      peak_q       <= '0;
      mean_q       <= '0;
      sum_q        <= '0;
      div_start_q  <= 1'b0;
      prod_start_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      div_start_q  <= 1'b0;
      prod_start_q <= 1'b0;
      if (res_valid_q && !result_stall_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (sample_valid_i) begin
            sample_q <= sample_i;
            state_q  <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          if (s_mag > peak_q) begin
            peak_q <= s_mag;
          end
          if (count_q != CountMax) begin
            count_q <= count_q + COUNT_WIDTH'(1);
          end
          scaled_q <= scaled;
          delta_q  <= scaled - mean_q;
          state_q  <= ST_MAG;
        end
        ST_MAG: begin
          dmag_q         <= delta_abs;
          neg_q          <= delta_q[AW-1];
          div_dividend_q <= delta_abs;
          div_divisor_q  <= count_q;
          div_start_q    <= 1'b1;
          state_q        <= ST_MDIV;
        end
        ST_MDIV: begin
          if (div_done) begin
            mean_q  <= neg_q ? mean_q - signed'(div_quot) : mean_q + signed'(div_quot);
            state_q <= ST_DELTA2;
          end
        end
        ST_DELTA2: begin
          delta_q <= scaled_q - mean_q;
          state_q <= ST_PSTART;
        end
        ST_PSTART: begin
          // the start pulse raised here makes the product unit sample |delta2| from delta_abs
          prod_start_q <= 1'b1;
          state_q      <= ST_PROD;
        end
        ST_PROD: begin
          if (prod_done) begin
            sum_q   <= sum_next;
            state_q <= ST_VSTART;
          end
        end
        ST_VSTART: begin
          if (count_q >= COUNT_WIDTH'(2)) begin
            div_dividend_q <= {1'b0, sum_q};
            div_divisor_q  <= count_q - COUNT_WIDTH'(1);
            div_start_q    <= 1'b1;
            state_q        <= ST_VDIV;
          end else begin
            var_q   <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_VDIV: begin
          if (div_done) begin
            var_q   <= div_quot[SW-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_valid_q || !result_stall_i) begin
            res_valid_q <= 1'b1;
            res_count_q <= OW'(count_q);
            res_peak_q  <= OW'(peak_q);
            res_mean_q  <= OW'(mean_q >>> MEAN_SHIFT);
            res_var_q   <= var_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign sample_stall_o      = (state_q != ST_IDLE);
  assign result_valid_o      = res_valid_q;
  assign sample_count_o      = res_count_q;
  assign largest_magnitude_o = res_peak_q;
  assign running_mean_o      = res_mean_q;
  assign sample_variance_o   = res_var_q;

endmodule

// ===== rtl/core/rmvs_checker.sv =====
// Port-level assertions for the running mean and variance block, with bind.
module rmvs_checker #(
  parameter int unsigned SAMPLE_WIDTH = rmvs_pkg::SampleWidthDef,
  parameter int unsigned COUNT_WIDTH  = rmvs_pkg::CountWidthDef
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 sample_valid_i,
  input logic                                 sample_stall_o,
  input logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  input logic                                 result_valid_o,
  input logic                                 result_stall_i,
  input logic [rmvs_pkg::OutWidth-1:0]        sample_count_o,
  input logic [rmvs_pkg::OutWidth-1:0]        largest_magnitude_o,
  input logic signed [rmvs_pkg::OutWidth-1:0] running_mean_o,
  input logic [rmvs_pkg::SumWidth-1:0]        sample_variance_o
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(sample_count_o) &&
      $stable(largest_magnitude_o) && $stable(running_mean_o) &&
      $stable(sample_variance_o))
    else $error("result word changed while stalled");

  // an accepted sample keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && !sample_stall_o |=> sample_stall_o)
    else $error("sample taken without entering the sequence");

  // a new result only appears at the end of a busy sequence
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(sample_stall_o))
    else $error("result appeared with no word in progress");

  // variance reads zero below two samples
  a_var_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (COUNT_WIDTH <= rmvs_pkg::OutWidth) &&
      (sample_count_o < rmvs_pkg::OutWidth'(2)) |-> sample_variance_o == '0)
    else $error("nonzero variance with fewer than two samples");

  // every valid result carries a nonzero count
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (COUNT_WIDTH <= rmvs_pkg::OutWidth) |-> sample_count_o != '0)
    else $error("result with zero sample count");

endmodule

bind running_mean_variance_stats rmvs_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_rmvs_checker (.*);
